### hw/rtl/clr_pkg.sv
// shared types and constants for the clipped line rasterizer
`default_nettype none

package clr_pkg;

  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned FRAME_W     = 13;
  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = CFG_INDEX_W'(1);

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = FRAME_W'(1024);
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = FRAME_W'(768);

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       operation;
    logic signed [FIELD_W-1:0] start_x;
    logic signed [FIELD_W-1:0] start_y;
    logic signed [FIELD_W-1:0] end_x;
    logic signed [FIELD_W-1:0] end_y;
    logic        [COLOR_W-1:0] line_color;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               in_frame;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic              in_frame;
    logic [ADDR_W-1:0] pixel_address;
  } pix_info_t;

endpackage

`default_nettype wire

### hw/rtl/clipped_line_rasterizer.sv
// clipped all-octant bresenham line rasterizer, top level
//
// usage: a start transaction on the in_ channel (operation = start) loads the
// two endpoints and the line color and produces nothing. each following step
// transaction produces one pixel on the out_ channel: its color, an in-frame
// flag, its row-major address (zero when clipped) and a last flag on the end
// pixel, after which the rasterizer is idle and further steps produce nothing.
// a start during a line replaces that line.
// frame_width (index 0) and frame_height (index 1) are written through the
// cfg_ port, which is always ready; write them only while the block is idle.
// a step's pixel goes to the output register, or to the skid entry while
// that one waits. throughput: one transaction per cycle while in_stall is
// low, set by the single bresenham state stage and the pixel output register.
// a two-entry output buffer (output register plus skid) lets the in_ side
// keep accepting while one pixel waits; in_stall rises only when both
// entries are full, so it is a register and does not follow out_stall
// combinationally. reset empties the buffer, drops any line and restores
// the frame to 1024 x 768.
`default_nettype none

module clipped_line_rasterizer
  import clr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // item channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_item_t               in_data,
  // pixel channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_data,
  // register writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [FRAME_W-1:0]     cfg_data
);

  localparam int unsigned SPAN_W = COORD_BITS + 1;
  localparam int unsigned ERR_W  = COORD_BITS + 3;

  // configuration
  logic [FRAME_W-1:0] frame_width_r;
  logic [FRAME_W-1:0] frame_height_r;

  // bresenham state
  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, target_x_r, target_y_r;
  logic signed [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt;
  logic        [SPAN_W-1:0]     span_x_r, span_y_r;
  logic                         step_x_neg_r, step_y_neg_r;
  logic signed [ERR_W-1:0]      error_r, error_nxt;
  logic        [COLOR_W-1:0]    held_color_r;
  logic                         line_active_r;

  // output buffer
  out_item_t out_r, skid_r;
  logic      out_valid_r, skid_valid_r;

  // handshakes
  logic in_fire, out_fire, is_start, push;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign is_start  = (in_data.operation == OP_START);
  assign push      = in_fire && !is_start && line_active_r;

  // ---------------------------------------------------------------------------
  // endpoint decode: low COORD_BITS bits or, if wider, the zero-extended field
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] x0, y0, x1, y1;

  if (COORD_BITS <= FIELD_W) begin : g_narrow
    assign x0 = in_data.start_x[COORD_BITS-1:0];
    assign y0 = in_data.start_y[COORD_BITS-1:0];
    assign x1 = in_data.end_x[COORD_BITS-1:0];
    assign y1 = in_data.end_y[COORD_BITS-1:0];
  end else begin : g_wide
    // the sign bit lies above the field, so the value is never negative
    assign x0 = {{(COORD_BITS-FIELD_W){1'b0}}, in_data.start_x};
    assign y0 = {{(COORD_BITS-FIELD_W){1'b0}}, in_data.start_y};
    assign x1 = {{(COORD_BITS-FIELD_W){1'b0}}, in_data.end_x};
    assign y1 = {{(COORD_BITS-FIELD_W){1'b0}}, in_data.end_y};
  end

  // start setup: spans, directions and the initial error
  logic signed [SPAN_W-1:0] dx, dy;
  logic        [SPAN_W-1:0] span_x_start, span_y_start;
  logic                     neg_x_start, neg_y_start;
  logic signed [ERR_W-1:0]  error_start;

  assign dx           = {x1[COORD_BITS-1], x1} - {x0[COORD_BITS-1], x0};
  assign dy           = {y1[COORD_BITS-1], y1} - {y0[COORD_BITS-1], y0};
  assign span_x_start = dx[SPAN_W-1] ? -dx : dx;
  assign span_y_start = dy[SPAN_W-1] ? -dy : dy;
  // a zero delta counts as the negative direction, it never moves anyway
  assign neg_x_start  = dx[SPAN_W-1] || (dx == '0);
  assign neg_y_start  = dy[SPAN_W-1] || (dy == '0);
  assign error_start  = {2'b00, span_x_start} - {2'b00, span_y_start};

  // ---------------------------------------------------------------------------
  // one bresenham step from the current state
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0]      e2, span_x_s, span_y_s;
  logic                         move_x, move_y, is_last;
  logic signed [COORD_BITS-1:0] unit_x, unit_y;

  assign span_x_s = {2'b00, span_x_r};
  assign span_y_s = {2'b00, span_y_r};
  assign e2       = error_r <<< 1;
  assign move_x   = e2 > -span_y_s;
  assign move_y   = e2 < span_x_s;
  assign is_last  = (cur_x_r == target_x_r) && (cur_y_r == target_y_r);
  assign unit_x   = step_x_neg_r ? '1 : {{(COORD_BITS-1){1'b0}}, 1'b1};
  assign unit_y   = step_y_neg_r ? '1 : {{(COORD_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    error_nxt = error_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (move_x) begin
      error_nxt = error_nxt - span_y_s;
      cur_x_nxt = cur_x_r + unit_x;
    end
    if (move_y) begin
      error_nxt = error_nxt + span_x_s;
      cur_y_nxt = cur_y_r + unit_y;
    end
  end

  // clip test and address of the pixel being emitted
  pix_info_t pix;

  clr_pixel #(
    .COORD_BITS (COORD_BITS)
  ) u_pixel (
    .cur_x        (cur_x_r),
    .cur_y        (cur_y_r),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .info         (pix)
  );

  out_item_t pix_item;

  assign pix_item.pixel_address = pix.pixel_address;
  assign pix_item.pixel_color   = held_color_r;
  assign pix_item.in_frame      = pix.in_frame;
  assign pix_item.last          = is_last;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RESET;
      frame_height_r <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
    end else if (in_fire) begin
      if (is_start) begin
        line_active_r <= 1'b1;
      end else if (line_active_r && is_last) begin
        line_active_r <= 1'b0;
      end
    end
  end

  // line datapath, no reset needed: only read while a line is active
  always_ff @(posedge clk) begin
    if (in_fire && is_start) begin
      cur_x_r      <= x0;
      cur_y_r      <= y0;
      target_x_r   <= x1;
      target_y_r   <= y1;
      span_x_r     <= span_x_start;
      span_y_r     <= span_y_start;
      step_x_neg_r <= neg_x_start;
      step_y_neg_r <= neg_y_start;
      error_r      <= error_start;
      held_color_r <= in_data.line_color;
    end else if (push && !is_last) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      error_r <= error_nxt;
    end
  end

  // two-entry output buffer; a push never meets a full skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_r <= skid_valid_r ? skid_r : pix_item;
    end else if (push) begin
      skid_r <= pix_item;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/clr_pixel.sv
// frame clip test and row-major address of the current pixel
`default_nettype none

module clr_pixel
  import clr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic signed [COORD_BITS-1:0] cur_x,
  input  wire logic signed [COORD_BITS-1:0] cur_y,
  input  wire logic        [FRAME_W-1:0]    frame_width,
  input  wire logic        [FRAME_W-1:0]    frame_height,
  output pix_info_t                         info
);

  localparam int unsigned CMP_W  = COORD_BITS + FRAME_W;
  localparam int unsigned PROD_W = 2 * FRAME_W;

  logic [CMP_W-1:0]  x_ext;
  logic [CMP_W-1:0]  y_ext;
  logic              in_rect;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] sum;

  // negative coordinates fail on the sign bit, the rest compare unsigned
  assign x_ext   = {{FRAME_W{1'b0}}, cur_x};
  assign y_ext   = {{FRAME_W{1'b0}}, cur_y};
  assign in_rect = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1] &&
                   (x_ext < {{COORD_BITS{1'b0}}, frame_width}) &&
                   (y_ext < {{COORD_BITS{1'b0}}, frame_height});

  // when inside, both coordinates fit in the frame register width
  assign prod = y_ext[FRAME_W-1:0] * frame_width;
  assign sum  = prod + {{FRAME_W{1'b0}}, x_ext[FRAME_W-1:0]};

  assign info.in_frame      = in_rect;
  assign info.pixel_address = in_rect ? sum[ADDR_W-1:0] : '0;

endmodule

`default_nettype wire

### verif/clipped_line_rasterizer_tb.sv
// self-checking testbench for the clipped bresenham line rasterizer
module clipped_line_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clr_pkg::*;

  // receiver stall behavior, picked per stretch of cycles
  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_LIGHT,
    FLOW_HEAVY
  } flow_mode_t;

  localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
  localparam int SETTLE_LIMIT = 60000;    // cycles to wait for the pipe to empty
  localparam int TAIL_CYCLES  = 8;        // latency margin after the last pixel
  localparam int PHASE_BUDGET = 90;       // random transactions per frame setting
  localparam int NUM_FRAMES   = 10;

  // frame settings walked through after the directed part, extremes included:
  // single pixel, nominal maximum, zero, and the full 13-bit value
  int unsigned frame_widths  [NUM_FRAMES] = '{64, 1, 4096, 0, 8191, 20, 4096, 1, 37, 1024};
  int unsigned frame_heights [NUM_FRAMES] = '{48, 1, 4096, 5, 8191, 12, 1, 4096, 0, 768};

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [FRAME_W-1:0]     cfg_data  = '0;

  // line commands waiting for the driver, pixels waiting for the monitor
  in_item_t  queued_commands [$];
  out_item_t expected_pixels [$];
  int        error_count = 0;

  // rasterizer state as the testbench expects it, reset values included
  logic signed [FIELD_W-1:0] pen_x = '0, pen_y = '0, goal_x = '0, goal_y = '0;
  logic [16:0]               run_x = '0, run_y = '0;
  logic signed [18:0]        slope_err = '0;
  logic                      x_back = 1'b0, y_back = 1'b0, drawing = 1'b0;
  logic [COLOR_W-1:0]        ink = '0;
  logic [FRAME_W-1:0]        width_reg  = FRAME_WIDTH_RESET;
  logic [FRAME_W-1:0]        height_reg = FRAME_HEIGHT_RESET;

  // sender burst control
  int burst_left = 1;
  int gap_left   = 0;

  // receiver stall control; a long hold-off is requested by bumping hold_requests
  int         hold_requests = 0;
  int         hold_served   = 0;
  int         hold_left     = 0;
  int         stall_left    = 0;
  flow_mode_t stall_mode    = FLOW_FREE;

  clipped_line_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // pixel prediction: a start loads the line, a step while drawing yields the
  // current pixel and then moves along the all-octant bresenham error rule
  // ---------------------------------------------------------------------------
  task automatic rasterize_command(input in_item_t cmd);
    int        x0, y0, x1, y1, px, py, w, h, err, e2;
    logic      on_frame, at_end;
    out_item_t pix;
    if (cmd.operation == OP_START) begin
      x0 = int'(cmd.start_x);
      y0 = int'(cmd.start_y);
      x1 = int'(cmd.end_x);
      y1 = int'(cmd.end_y);
      pen_x     = cmd.start_x;
      pen_y     = cmd.start_y;
      goal_x    = cmd.end_x;
      goal_y    = cmd.end_y;
      run_x     = 17'((x1 >= x0) ? x1 - x0 : x0 - x1);
      run_y     = 17'((y1 >= y0) ? y1 - y0 : y0 - y1);
      x_back    = !(x0 < x1);
      y_back    = !(y0 < y1);
      slope_err = 19'(int'(run_x) - int'(run_y));
      ink       = cmd.line_color;
      // any line in progress is simply dropped
      drawing   = 1'b1;
    end else if (drawing) begin
      px = int'(pen_x);
      py = int'(pen_y);
      w  = int'(width_reg);
      h  = int'(height_reg);
      // a zero frame register leaves nothing in frame
      on_frame = px >= 0 && py >= 0 && px < w && py < h;
      at_end   = (pen_x == goal_x) && (pen_y == goal_y);
      // oversized frames wrap the address to its 24 bits
      pix.pixel_address = on_frame ? ADDR_W'(py * w + px) : '0;
      pix.pixel_color   = ink;
      pix.in_frame      = on_frame;
      pix.last          = at_end;
      expected_pixels.push_back(pix);
      if (at_end) begin
        drawing = 1'b0;
      end else begin
        err = int'(slope_err);
        e2  = 2 * err;
        // both tests use the error from before this step
        if (e2 > -int'(run_y)) begin
          err   = err - int'(run_y);
          pen_x = FIELD_W'(px + (x_back ? -1 : 1));
        end
        if (e2 < int'(run_x)) begin
          err   = err + int'(run_x);
          pen_y = FIELD_W'(py + (y_back ? -1 : 1));
        end
        slope_err = 19'(err);
      end
    end
    // a step with no line in progress changes nothing and yields nothing
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of random length with random gaps; the payload holds while
  // stalled and in_valid is only touched when the current transaction is done
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rasterize_command(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (queued_commands.size() != 0) begin
          in_data  <= queued_commands.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            // many bursts run straight into the next one
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 :
                          ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) :
                                                        $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every accepted pixel is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
    end
  endtask

  task automatic check_pixel(input out_item_t got);
    out_item_t want;
    if (expected_pixels.size() == 0) begin
      error_count++;
      $display("%0t ns: pixel with none expected, expected nothing, actual 0x%0h",
               $time, got);
      return;
    end
    want = expected_pixels.pop_front();
    compare_field("pixel_address", 32'(want.pixel_address), 32'(got.pixel_address));
    compare_field("pixel_color", want.pixel_color, got.pixel_color);
    compare_field("in_frame", 32'(want.in_frame), 32'(got.in_frame));
    compare_field("last", 32'(want.last), 32'(got.last));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_pixel(out_data);
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall pattern: free, light and heavy stretches, plus a long
  // hold-off on request so the output buffer fills and in_stall rises
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= flow_mode_t'($urandom_range(0, 2));
        stall_left <= $urandom_range(8, 60);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:    out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t line_item(input int x0, input int y0, input int x1,
                                         input int y1, input logic [COLOR_W-1:0] color);
    in_item_t cmd;
    cmd.operation  = OP_START;
    cmd.start_x    = FIELD_W'(x0);
    cmd.start_y    = FIELD_W'(y0);
    cmd.end_x      = FIELD_W'(x1);
    cmd.end_y      = FIELD_W'(y1);
    cmd.line_color = color;
    return cmd;
  endfunction

  // steps carry junk in the unused fields
  function automatic in_item_t step_item();
    in_item_t cmd;
    cmd.operation  = OP_STEP;
    cmd.start_x    = FIELD_W'($urandom);
    cmd.start_y    = FIELD_W'($urandom);
    cmd.end_x      = FIELD_W'($urandom);
    cmd.end_y      = FIELD_W'($urandom);
    cmd.line_color = $urandom;
    return cmd;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // mostly around the frame, often right at its edges, sometimes anywhere
  function automatic int pick_coord(input int span);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return int'($urandom_range(0, span + 16)) - 8;
    if (sel < 9) return clamp_coord((($urandom_range(0, 1) == 0) ? 0 : span) +
                                    int'($urandom_range(0, 4)) - 2);
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // random lines for the current frame: mostly drawn to the end, some cut off
  // by the next start, some followed by steps that find no line
  task automatic queue_lines(input int budget);
    int made, pick, spread, x0, y0, x1, y1, dx, dy, pixels, steps;
    made = 0;
    while (made < budget) begin
      pick = $urandom_range(0, 99);
      x0 = pick_coord(int'(width_reg));
      y0 = pick_coord(int'(height_reg));
      if (pick < 4) begin
        // endpoints anywhere: far too long to finish, always cut short
        x1 = int'($urandom_range(0, 65535)) - 32768;
        y1 = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        spread = ($urandom_range(0, 9) == 0) ? 160 : 20;
        x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * spread)) - spread);
        y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * spread)) - spread);
      end
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      pixels = ((dx > dy) ? dx : dy) + 1;
      steps  = (pick < 16) ? $urandom_range(0, (pixels < 30) ? pixels - 1 : 30) : pixels;
      queued_commands.push_back(line_item(x0, y0, x1, y1, $urandom));
      repeat (steps) queued_commands.push_back(step_item());
      made += steps + 1;
      if (pick >= 90) begin
        repeat ($urandom_range(1, 3)) queued_commands.push_back(step_item());
      end
    end
  endtask

  // sender pause: wait until everything is sent and every pixel is back
  task automatic settle();
    int waited;
    waited = 0;
    while ((queued_commands.size() != 0 || in_valid || expected_pixels.size() != 0) &&
           waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_pixels.size() != 0) begin
      error_count++;
      $display("%0t ns: missing pixels, expected %0d more, actual none",
               $time, expected_pixels.size());
      expected_pixels.delete();
    end
    // a trailing start or idle step produces nothing, so allow it to finish
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // register write while the rasterizer is idle
  task automatic write_frame_reg(input logic [CFG_INDEX_W-1:0] index,
                                 input int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= FRAME_W'(value);
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == CFG_FRAME_WIDTH) begin
      width_reg = FRAME_W'(value);
    end else begin
      height_reg = FRAME_W'(value);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset frame of 1024 x 768
    queued_commands.push_back(step_item());                          // step with no line
    queued_commands.push_back(line_item(5, 7, 5, 7, 32'hFFFF_FFFF)); // single pixel line
    queued_commands.push_back(step_item());
    queued_commands.push_back(step_item());                          // idle again
    queued_commands.push_back(line_item(-32768, -32768, 32767, 32767, 32'h0));
    repeat (2) queued_commands.push_back(step_item());
    // replaces the line still in progress
    queued_commands.push_back(line_item(32767, -32768, -32768, 32767, 32'hA5A5_A5A5));
    queued_commands.push_back(step_item());
    // starts in the bottom right corner and leaves through the bottom
    queued_commands.push_back(line_item(1023, 767, 1020, 771, 32'h5A5A_5A5A));
    repeat (5) queued_commands.push_back(step_item());
    // enters through the left edge
    queued_commands.push_back(line_item(-2, 0, 2, -1, 32'h0123_4567));
    repeat (5) queued_commands.push_back(step_item());
    settle();

    for (int p = 0; p < NUM_FRAMES; p++) begin
      write_frame_reg(CFG_FRAME_WIDTH, frame_widths[p]);
      write_frame_reg(CFG_FRAME_HEIGHT, frame_heights[p]);
      queue_lines(PHASE_BUDGET);
      // hold the receiver off while a full phase is offered
      if (p == 2 || p == 6) begin
        hold_requests <= hold_requests + 1;
      end
      // a single pixel line guarantees the rasterizer ends the phase idle
      queued_commands.push_back(line_item(0, 0, 0, 0, $urandom));
      queued_commands.push_back(step_item());
      settle();
    end

    if (error_count == 0) begin
      $display("[clipped_line_rasterizer] OK");
    end else begin
      $display("[clipped_line_rasterizer] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("[clipped_line_rasterizer] ERROR");
    $finish;
  end

endmodule

### files.f
hw/rtl/clr_pkg.sv
hw/rtl/clr_pixel.sv
hw/rtl/clipped_line_rasterizer.sv
verif/clipped_line_rasterizer_tb.sv
